// ===== sv/taabb_pkg.sv =====
// Shared types and constants for the transformed bounding box accumulator.
package taabb_pkg;

   localparam int COORD_BITS  = 32;
   localparam int FRAC_BITS   = 16;
   localparam int NUM_AXES    = 3;
   localparam int ROW_WORDS   = 4;
   localparam int PEND_ROWS   = 2;
   localparam int CORNER_BITS = NUM_AXES;
   localparam int LANE_LAT    = 3;
   localparam int PROD_BITS   = 2 * COORD_BITS;
   localparam int SUM_BITS    = 2 * COORD_BITS + 2;

   localparam logic [CORNER_BITS-1:0] CORNER_LAST = {CORNER_BITS{1'b1}};

   localparam logic [1:0] MODE_VERTEX = 2'd0;
   localparam logic [1:0] MODE_ROW    = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;
   localparam logic [1:0] ROW_LAST    = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef coord_type vec3_type [NUM_AXES];
   typedef coord_type row_type [ROW_WORDS];

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

endpackage

// ===== sv/taabb_lane.sv =====
// One transform lane: dot product of a matrix row with a corner, floor shift and saturation.
module taabb_lane (
   input  logic                clock,
   input  taabb_pkg::row_type   coef,
   input  taabb_pkg::coord_type x,
   input  taabb_pkg::coord_type y,
   input  taabb_pkg::coord_type z,
   output taabb_pkg::coord_type result
);

   logic signed [taabb_pkg::PROD_BITS-1:0] px_ff, py_ff, pz_ff;
   logic signed [taabb_pkg::PROD_BITS-1:0] px_in, py_in, pz_in;
   logic signed [taabb_pkg::SUM_BITS-1:0]  dsh_ff, dsh_in;
   logic signed [taabb_pkg::SUM_BITS-1:0]  s01_ff, s01_in, s2d_ff, s2d_in;
   logic signed [taabb_pkg::SUM_BITS-1:0]  total, shifted;
   logic [taabb_pkg::SUM_BITS-taabb_pkg::COORD_BITS:0] head;
   taabb_pkg::coord_type                   result_ff, result_in;

   always_comb begin
      px_in  = taabb_pkg::PROD_BITS'(coef[0]) * taabb_pkg::PROD_BITS'(x);
      py_in  = taabb_pkg::PROD_BITS'(coef[1]) * taabb_pkg::PROD_BITS'(y);
      pz_in  = taabb_pkg::PROD_BITS'(coef[2]) * taabb_pkg::PROD_BITS'(z);
      dsh_in = taabb_pkg::SUM_BITS'(coef[3]) <<< taabb_pkg::FRAC_BITS;
   end

   always_comb begin
      s01_in = taabb_pkg::SUM_BITS'(px_ff) + taabb_pkg::SUM_BITS'(py_ff);
      s2d_in = taabb_pkg::SUM_BITS'(pz_ff) + dsh_ff;
   end

   // The sum fits the coordinate range when every bit above its sign bit matches it.
   always_comb begin
      total   = s01_ff + s2d_ff;
      shifted = total >>> taabb_pkg::FRAC_BITS;
      head    = shifted[taabb_pkg::SUM_BITS-1:taabb_pkg::COORD_BITS-1];
      if ((&head) || !(|head)) begin
         result_in = shifted[taabb_pkg::COORD_BITS-1:0];
      end else if (shifted[taabb_pkg::SUM_BITS-1]) begin
         result_in = taabb_pkg::COORD_MIN;
      end else begin
         result_in = taabb_pkg::COORD_MAX;
      end
   end

   always_ff @(posedge clock) begin
      px_ff     <= px_in;
      py_ff     <= py_in;
      pz_ff     <= pz_in;
      dsh_ff    <= dsh_in;
      s01_ff    <= s01_in;
      s2d_ff    <= s2d_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== sv/taabb_merge.sv =====
// Merging stage: folds the three lane results into the world box, or clears the box.
module taabb_merge (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic                 fold,
   input  taabb_pkg::vec3_type  point,
   output taabb_pkg::vec3_type  world_low,
   output taabb_pkg::vec3_type  world_high,
   output logic                 world_valid
);

   taabb_pkg::vec3_type low_ff, low_in, high_ff, high_in;
   logic                valid_ff, valid_in;

   always_comb begin
      low_in   = low_ff;
      high_in  = high_ff;
      valid_in = valid_ff;
      priority if (clear) begin
         for (int k = 0; k < taabb_pkg::NUM_AXES; k++) begin
            low_in[k]  = taabb_pkg::COORD_MAX;
            high_in[k] = taabb_pkg::COORD_MIN;
         end
         valid_in = 1'b0;
      end else if (fold) begin
         for (int k = 0; k < taabb_pkg::NUM_AXES; k++) begin
            if (point[k] < low_ff[k]) begin
               low_in[k] = point[k];
            end
            if (point[k] > high_ff[k]) begin
               high_in[k] = point[k];
            end
         end
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < taabb_pkg::NUM_AXES; k++) begin
            low_ff[k]  <= taabb_pkg::COORD_MAX;
            high_ff[k] <= taabb_pkg::COORD_MIN;
         end
         valid_ff <= 1'b0;
      end else begin
         low_ff   <= low_in;
         high_ff  <= high_in;
         valid_ff <= valid_in;
      end
   end

   assign world_low   = low_ff;
   assign world_high  = high_ff;
   assign world_valid = valid_ff;

endmodule

// ===== sv/transformed_aabb_accumulator.sv =====
// Top level of the transformed bounding box accumulator: local box, row buffer, lanes, sequencer.
//
// Vertex, clear and rows 0 and 1 keep busy low, so they can be issued back to back. A row 2
// word raises busy: with vertices loaded the eight box corners are issued one per cycle into
// three parallel lanes (one per matrix row, each a three-stage multiply/add/saturate pipeline),
// and busy stays high until the cycle that carries the result; with no vertices loaded busy is
// high for one cycle, which carries the result. The result is held on the rsp_ ports for
// exactly the cycle rsp_strobe is high and cannot be stalled; the receiver must take it then.
module transformed_aabb_accumulator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_mode,
   input  logic [1:0]           req_row,
   input  taabb_pkg::coord_type req_a,
   input  taabb_pkg::coord_type req_b,
   input  taabb_pkg::coord_type req_c,
   input  taabb_pkg::coord_type req_d,
   output logic                 rsp_strobe,
   output taabb_pkg::coord_type rsp_world_min_x,
   output taabb_pkg::coord_type rsp_world_min_y,
   output taabb_pkg::coord_type rsp_world_min_z,
   output taabb_pkg::coord_type rsp_world_max_x,
   output taabb_pkg::coord_type rsp_world_max_y,
   output taabb_pkg::coord_type rsp_world_max_z,
   output logic                 rsp_world_empty
);

   taabb_pkg::state_type state_ff, state_in;
   logic                 accept, is_vertex, is_clear, is_row, row_store, row_last;
   logic                 issue;
   taabb_pkg::vec3_type  item_xyz;
   taabb_pkg::row_type   item_row;
   taabb_pkg::vec3_type  local_low_ff, local_low_in, local_high_ff, local_high_in;
   logic                 local_valid_ff, local_valid_in;
   taabb_pkg::row_type   rows_ff [taabb_pkg::PEND_ROWS];
   taabb_pkg::row_type   last_row_ff;
   taabb_pkg::row_type   lane_coef [taabb_pkg::NUM_AXES];
   logic [taabb_pkg::CORNER_BITS-1:0] corner_ff, corner_in;
   taabb_pkg::vec3_type  corner_xyz;
   taabb_pkg::vec3_type  lane_result;
   taabb_pkg::ctl_type   pipe_ff [taabb_pkg::LANE_LAT];
   taabb_pkg::ctl_type   pipe_head;
   taabb_pkg::vec3_type  world_low, world_high;
   logic                 world_valid;

   assign accept    = start && !busy;
   assign is_vertex = accept && (req_mode == taabb_pkg::MODE_VERTEX);
   assign is_clear  = accept && (req_mode == taabb_pkg::MODE_CLEAR);
   assign is_row    = accept && (req_mode == taabb_pkg::MODE_ROW);
   assign row_store = is_row && (req_row < taabb_pkg::ROW_LAST);
   assign row_last  = is_row && (req_row == taabb_pkg::ROW_LAST);

   assign item_xyz = '{req_a, req_b, req_c};
   assign item_row = '{req_a, req_b, req_c, req_d};

   // Local object-space box.
   always_comb begin
      local_low_in   = local_low_ff;
      local_high_in  = local_high_ff;
      local_valid_in = local_valid_ff;
      priority if (is_clear) begin
         for (int k = 0; k < taabb_pkg::NUM_AXES; k++) begin
            local_low_in[k]  = taabb_pkg::COORD_MAX;
            local_high_in[k] = taabb_pkg::COORD_MIN;
         end
         local_valid_in = 1'b0;
      end else if (is_vertex) begin
         for (int k = 0; k < taabb_pkg::NUM_AXES; k++) begin
            if (item_xyz[k] < local_low_ff[k]) begin
               local_low_in[k] = item_xyz[k];
            end
            if (item_xyz[k] > local_high_ff[k]) begin
               local_high_in[k] = item_xyz[k];
            end
         end
         local_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < taabb_pkg::NUM_AXES; k++) begin
            local_low_ff[k]  <= taabb_pkg::COORD_MAX;
            local_high_ff[k] <= taabb_pkg::COORD_MIN;
         end
         local_valid_ff <= 1'b0;
      end else begin
         local_low_ff   <= local_low_in;
         local_high_ff  <= local_high_in;
         local_valid_ff <= local_valid_in;
      end
   end

   // Matrix row buffers.
   always_ff @(posedge clock) begin
      if (row_store) begin
         rows_ff[req_row[0]] <= item_row;
      end
      if (row_last) begin
         last_row_ff <= item_row;
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         taabb_pkg::ST_IDLE: begin
            if (row_last) begin
               state_in = local_valid_ff ? taabb_pkg::ST_RUN : taabb_pkg::ST_EMIT;
            end
         end
         taabb_pkg::ST_RUN: begin
            if (corner_ff == taabb_pkg::CORNER_LAST) begin
               state_in = taabb_pkg::ST_DRAIN;
            end
         end
         taabb_pkg::ST_DRAIN: begin
            if (pipe_head.valid && pipe_head.last) begin
               state_in = taabb_pkg::ST_EMIT;
            end
         end
         taabb_pkg::ST_EMIT: begin
            state_in = taabb_pkg::ST_IDLE;
         end
         default: begin
            state_in = taabb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy       = 1'b1;
      issue      = 1'b0;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         taabb_pkg::ST_IDLE:  busy = 1'b0;
         taabb_pkg::ST_RUN:   issue = 1'b1;
         taabb_pkg::ST_DRAIN: busy = 1'b1;
         taabb_pkg::ST_EMIT:  rsp_strobe = 1'b1;
         default:             busy = 1'b1;
      endcase
   end

   assign corner_in = issue ? corner_ff + 1'b1 : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= taabb_pkg::ST_IDLE;
         corner_ff <= '0;
      end else begin
         state_ff  <= state_in;
         corner_ff <= corner_in;
      end
   end

   // Control travels alongside the lane pipelines.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < taabb_pkg::LANE_LAT; s++) begin
            pipe_ff[s] <= '0;
         end
      end else begin
         pipe_ff[0].valid <= issue;
         pipe_ff[0].last  <= issue && (corner_ff == taabb_pkg::CORNER_LAST);
         for (int s = 1; s < taabb_pkg::LANE_LAT; s++) begin
            pipe_ff[s] <= pipe_ff[s-1];
         end
      end
   end

   assign pipe_head = pipe_ff[taabb_pkg::LANE_LAT-1];

   // Each corner takes the high bound on axis k when bit k of the corner number is set.
   always_comb begin
      for (int k = 0; k < taabb_pkg::NUM_AXES; k++) begin
         corner_xyz[k] = corner_ff[k] ? local_high_ff[k] : local_low_ff[k];
      end
   end

   always_comb begin
      lane_coef[0] = rows_ff[0];
      lane_coef[1] = rows_ff[1];
      lane_coef[2] = last_row_ff;
   end

   for (genvar g = 0; g < taabb_pkg::NUM_AXES; g++) begin : g_lane
      taabb_lane u_lane (
         .clock  (clock),
         .coef   (lane_coef[g]),
         .x      (corner_xyz[0]),
         .y      (corner_xyz[1]),
         .z      (corner_xyz[2]),
         .result (lane_result[g])
      );
   end

   taabb_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .clear       (is_clear),
      .fold        (pipe_head.valid),
      .point       (lane_result),
      .world_low   (world_low),
      .world_high  (world_high),
      .world_valid (world_valid)
   );

   assign rsp_world_min_x = world_valid ? world_low[0]  : '0;
   assign rsp_world_min_y = world_valid ? world_low[1]  : '0;
   assign rsp_world_min_z = world_valid ? world_low[2]  : '0;
   assign rsp_world_max_x = world_valid ? world_high[0] : '0;
   assign rsp_world_max_y = world_valid ? world_high[1] : '0;
   assign rsp_world_max_z = world_valid ? world_high[2] : '0;
   assign rsp_world_empty = !world_valid;

endmodule

// ===== test/tb_transformed_aabb_accumulator.sv =====
// Self-checking testbench for the transformed bounding box accumulator.
module tb_transformed_aabb_accumulator;
   timeunit 1ns;
   timeprecision 1ps;
   import taabb_pkg::*;

   localparam int HALF_PERIOD  = 2;
   localparam int RESET_CYCLES = 12;
   localparam int IDLE_PCT     = 21;
   localparam int RANDOM_ITEMS = 600;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 32;
   localparam int MAX_REPORTS  = 10;
   localparam int QUIET_FIRST  = 250;
   localparam int QUIET_LAST   = 400;
   localparam int DIR_COUNT    = 22;

   localparam logic [1:0] MODE_BAD = 2'd3;
   localparam logic [1:0] ROW_TOP  = 2'd0;
   localparam logic [1:0] ROW_MID  = 2'd1;
   localparam logic [1:0] ROW_BAD  = 2'd3;

   localparam coord_type ZERO    = '0;
   localparam coord_type ONE     = 32'sh0001_0000;
   localparam coord_type HALF    = 32'sh0000_8000;
   localparam coord_type NEG_ONE = -32'sd1;

   typedef struct packed {
      coord_type min_x, min_y, min_z;
      coord_type max_x, max_y, max_z;
      logic      empty;
   } world_box_type;

   typedef struct packed {
      logic [1:0]    mode;
      logic [1:0]    row;
      coord_type     a, b, c, d;
      logic          fixed_exp;
      world_box_type box;
   } box_cmd_type;

   localparam world_box_type NO_BOX    = '0;
   localparam world_box_type EMPTY_BOX = '{ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, 1'b1};
   localparam world_box_type FULL_BOX  =
      '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0};
   localparam world_box_type SAT_BOX   =
      '{COORD_MAX, COORD_MIN, ZERO, COORD_MAX, COORD_MIN, ZERO, 1'b0};

   box_cmd_type dir_tbl [DIR_COUNT] = '{
      // Identity rows, then an instance with no vertices loaded.
      '{MODE_ROW,    ROW_TOP,  ONE,  ZERO, ZERO, ZERO, 1'b0, NO_BOX},
      '{MODE_ROW,    ROW_MID,  ZERO, ONE,  ZERO, ZERO, 1'b0, NO_BOX},
      '{MODE_ROW,    ROW_LAST, ZERO, ZERO, ONE,  ZERO, 1'b1, EMPTY_BOX},
      // Opposite ends of the coordinate range pass through the identity unchanged.
      '{MODE_VERTEX, ROW_BAD,  COORD_MAX, COORD_MAX, COORD_MAX, NEG_ONE, 1'b0, NO_BOX},
      '{MODE_VERTEX, ROW_TOP,  COORD_MIN, COORD_MIN, COORD_MIN, ZERO, 1'b0, NO_BOX},
      '{MODE_ROW,    ROW_LAST, ZERO, ZERO, ONE, ZERO, 1'b1, FULL_BOX},
      '{MODE_CLEAR,  ROW_BAD,  NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE, 1'b0, NO_BOX},
      '{MODE_ROW,    ROW_LAST, ZERO, ZERO, ONE, ZERO, 1'b1, EMPTY_BOX},
      // Sums far out of range saturate at both ends.
      '{MODE_VERTEX, ROW_MID,  COORD_MAX, COORD_MAX, COORD_MAX, ZERO, 1'b0, NO_BOX},
      '{MODE_ROW,    ROW_TOP,  COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, NO_BOX},
      '{MODE_ROW,    ROW_MID,  COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, NO_BOX},
      '{MODE_ROW,    ROW_LAST, ZERO, ZERO, ZERO, ZERO, 1'b1, SAT_BOX},
      // An unused mode and an unused row index must leave every box and row alone.
      '{MODE_BAD,    ROW_MID,  NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE, 1'b0, NO_BOX},
      '{MODE_ROW,    ROW_BAD,  NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE, 1'b0, NO_BOX},
      '{MODE_ROW,    ROW_LAST, ZERO, ZERO, ZERO, ZERO, 1'b1, SAT_BOX},
      // Half coefficients on tiny negative coordinates exercise the floor shift.
      '{MODE_CLEAR,  ROW_TOP,  ZERO, ZERO, ZERO, ZERO, 1'b0, NO_BOX},
      '{MODE_VERTEX, ROW_TOP,  NEG_ONE, 32'sd1, 32'sd3, ZERO, 1'b0, NO_BOX},
      '{MODE_VERTEX, ROW_MID,  32'sd5, -32'sd7, ZERO, ZERO, 1'b0, NO_BOX},
      '{MODE_ROW,    ROW_TOP,  HALF, ZERO, ZERO, NEG_ONE, 1'b0, NO_BOX},
      '{MODE_ROW,    ROW_MID,  ZERO, -HALF, HALF, ZERO, 1'b0, NO_BOX},
      '{MODE_ROW,    ROW_LAST, ONE, -ONE, COORD_MAX, COORD_MIN, 1'b0, NO_BOX},
      '{MODE_ROW,    ROW_LAST, HALF, HALF, -HALF, ONE, 1'b0, NO_BOX}
   };

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       start     = 1'b0;
   logic [1:0] req_mode  = '0;
   logic [1:0] req_row   = '0;
   coord_type  req_a     = '0;
   coord_type  req_b     = '0;
   coord_type  req_c     = '0;
   coord_type  req_d     = '0;
   logic       busy;
   logic       rsp_strobe;
   coord_type  rsp_world_min_x, rsp_world_min_y, rsp_world_min_z;
   coord_type  rsp_world_max_x, rsp_world_max_y, rsp_world_max_z;
   logic       rsp_world_empty;

   box_cmd_type   stim_q[$];
   world_box_type world_box_q[$];
   int            live_items   = 0;
   int            next_item    = 0;
   int            stall_cycles = 0;
   int            mismatches   = 0;

   // Predicted block state.
   coord_type  obj_lo [NUM_AXES];
   coord_type  obj_hi [NUM_AXES];
   coord_type  wld_lo [NUM_AXES];
   coord_type  wld_hi [NUM_AXES];
   logic       obj_seen;
   logic       wld_seen;
   coord_type  held_rows [PEND_ROWS][ROW_WORDS];

   transformed_aabb_accumulator u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_row         (req_row),
      .req_a           (req_a),
      .req_b           (req_b),
      .req_c           (req_c),
      .req_d           (req_d),
      .rsp_strobe      (rsp_strobe),
      .rsp_world_min_x (rsp_world_min_x),
      .rsp_world_min_y (rsp_world_min_y),
      .rsp_world_min_z (rsp_world_min_z),
      .rsp_world_max_x (rsp_world_max_x),
      .rsp_world_max_y (rsp_world_max_y),
      .rsp_world_max_z (rsp_world_max_z),
      .rsp_world_empty (rsp_world_empty)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic coord_type span_value(input int unsigned span);
      return coord_type'($urandom_range(0, 2 * span - 1)) - coord_type'(span);
   endfunction

   function automatic coord_type rand_position();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return COORD_MAX;
      if (pick < 10) return COORD_MIN;
      if (pick < 45) return coord_type'($urandom);
      return span_value(32'h0100_0000);
   endfunction

   function automatic coord_type rand_coeff();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) return COORD_MAX;
      if (pick < 8) return COORD_MIN;
      if (pick < 20) return coord_type'($urandom);
      return span_value(32'h0004_0000);
   endfunction

   // One output coordinate: exact sum, floor shift out of the fraction, then saturate.
   function automatic coord_type transform_coord(input coord_type ca, cb, cc, cd, x, y, z);
      logic signed [95:0] wa, wb, wc, wd, wx, wy, wz, acc;
      wa = ca; wb = cb; wc = cc; wd = cd;
      wx = x;  wy = y;  wz = z;
      acc = (wd <<< FRAC_BITS) + wa * wx + wb * wy + wc * wz;
      acc = acc >>> FRAC_BITS;
      if (acc > COORD_MAX) return COORD_MAX;
      if (acc < COORD_MIN) return COORD_MIN;
      return acc[COORD_BITS-1:0];
   endfunction

   task automatic clear_boxes();
      int k;
      for (k = 0; k < NUM_AXES; k++) begin
         obj_lo[k] = COORD_MAX;
         obj_hi[k] = COORD_MIN;
         wld_lo[k] = COORD_MAX;
         wld_hi[k] = COORD_MIN;
      end
      obj_seen = 1'b0;
      wld_seen = 1'b0;
   endtask

   task automatic track_item(input box_cmd_type it);
      coord_type     pos [NUM_AXES];
      coord_type     pt [NUM_AXES];
      world_box_type want;
      int            k, n;
      pos[0] = it.a;
      pos[1] = it.b;
      pos[2] = it.c;
      case (it.mode)
         MODE_VERTEX: begin
            for (k = 0; k < NUM_AXES; k++) begin
               if (pos[k] < obj_lo[k]) obj_lo[k] = pos[k];
               if (pos[k] > obj_hi[k]) obj_hi[k] = pos[k];
            end
            obj_seen = 1'b1;
         end
         MODE_CLEAR: clear_boxes();
         MODE_ROW: begin
            if (it.row == ROW_TOP || it.row == ROW_MID) begin
               held_rows[it.row][0] = it.a;
               held_rows[it.row][1] = it.b;
               held_rows[it.row][2] = it.c;
               held_rows[it.row][3] = it.d;
            end else if (it.row == ROW_LAST) begin
               if (obj_seen) begin
                  for (n = 0; n < 8; n++) begin
                     for (k = 0; k < NUM_AXES; k++)
                        pos[k] = n[k] ? obj_hi[k] : obj_lo[k];
                     for (k = 0; k < PEND_ROWS; k++)
                        pt[k] = transform_coord(held_rows[k][0], held_rows[k][1],
                                                held_rows[k][2], held_rows[k][3],
                                                pos[0], pos[1], pos[2]);
                     pt[2] = transform_coord(it.a, it.b, it.c, it.d, pos[0], pos[1], pos[2]);
                     for (k = 0; k < NUM_AXES; k++) begin
                        if (pt[k] < wld_lo[k]) wld_lo[k] = pt[k];
                        if (pt[k] > wld_hi[k]) wld_hi[k] = pt[k];
                     end
                  end
                  wld_seen = 1'b1;
               end
               want.min_x = wld_seen ? wld_lo[0] : ZERO;
               want.min_y = wld_seen ? wld_lo[1] : ZERO;
               want.min_z = wld_seen ? wld_lo[2] : ZERO;
               want.max_x = wld_seen ? wld_hi[0] : ZERO;
               want.max_y = wld_seen ? wld_hi[1] : ZERO;
               want.max_z = wld_seen ? wld_hi[2] : ZERO;
               want.empty = !wld_seen;
               world_box_q = {world_box_q, (it.fixed_exp ? it.box : want)};
            end
         end
         default: ;
      endcase
   endtask

   task automatic push_item(input logic [1:0] mode, input logic [1:0] row,
                            input coord_type a, b, c, d);
      box_cmd_type it;
      it = '{mode, row, a, b, c, d, 1'b0, NO_BOX};
      stim_q = {stim_q, it};
      if (mode != MODE_BAD && !(mode == MODE_ROW && row == ROW_BAD)) live_items++;
   endtask

   task automatic push_row(input logic [1:0] row);
      push_item(MODE_ROW, row, rand_coeff(), rand_coeff(), rand_coeff(), rand_position());
   endtask

   task automatic check_field(input string what, input logic [31:0] want, got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
      end
   endtask

   initial begin
      int unsigned pick;
      logic        swap;
      clear_boxes();
      foreach (held_rows[i, j]) held_rows[i][j] = ZERO;
      foreach (dir_tbl[i]) stim_q = {stim_q, dir_tbl[i]};
      // Mostly whole instances (vertices, rows 0 and 1, row 2), with clears and noise between.
      while (live_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            repeat ($urandom_range(0, 5))
               push_item(MODE_VERTEX, 2'($urandom), rand_position(), rand_position(),
                         rand_position(), coord_type'($urandom));
            if ($urandom_range(0, 9) != 0) begin
               swap = $urandom_range(0, 1);
               push_row(swap ? ROW_MID : ROW_TOP);
               push_row(swap ? ROW_TOP : ROW_MID);
            end
            push_row(ROW_LAST);
         end else if (pick < 82) begin
            push_item(MODE_CLEAR, 2'($urandom), coord_type'($urandom), coord_type'($urandom),
                      coord_type'($urandom), coord_type'($urandom));
         end else if (pick < 90) begin
            push_item(MODE_BAD, 2'($urandom), coord_type'($urandom), coord_type'($urandom),
                      coord_type'($urandom), coord_type'($urandom));
         end else if (pick < 96) begin
            push_item(MODE_ROW, ROW_BAD, coord_type'($urandom), coord_type'($urandom),
                      coord_type'($urandom), coord_type'($urandom));
         end else begin
            push_row($urandom_range(0, 1) ? ROW_MID : ROW_TOP);
         end
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      world_box_type want;
      logic          taken;
      logic          quiet;
      taken = start && !busy;
      if (reset) begin
         start <= 1'b0;
         stall_cycles = 0;
      end else begin
         if (taken) begin
            track_item(stim_q[next_item]);
            next_item++;
         end
         if (rsp_strobe) begin
            if (world_box_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("result word with nothing expected: min %h %h %h max %h %h %h",
                           rsp_world_min_x, rsp_world_min_y, rsp_world_min_z,
                           rsp_world_max_x, rsp_world_max_y, rsp_world_max_z);
            end else begin
               want = world_box_q.pop_front();
               check_field("world_min_x", want.min_x, rsp_world_min_x);
               check_field("world_min_y", want.min_y, rsp_world_min_y);
               check_field("world_min_z", want.min_z, rsp_world_min_z);
               check_field("world_max_x", want.max_x, rsp_world_max_x);
               check_field("world_max_y", want.max_y, rsp_world_max_y);
               check_field("world_max_z", want.max_z, rsp_world_max_z);
               check_field("world_empty", 32'(want.empty), 32'(rsp_world_empty));
            end
         end
         if (taken || rsp_strobe) stall_cycles = 0;
         else stall_cycles++;
         // A word that is not yet taken stays on the bus; gaps only open between words.
         if (taken || !start) begin
            quiet = next_item >= DIR_COUNT + QUIET_FIRST && next_item < DIR_COUNT + QUIET_LAST;
            if (next_item < stim_q.size() && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
               start    <= 1'b1;
               req_mode <= stim_q[next_item].mode;
               req_row  <= stim_q[next_item].row;
               req_a    <= stim_q[next_item].a;
               req_b    <= stim_q[next_item].b;
               req_c    <= stim_q[next_item].c;
               req_d    <= stim_q[next_item].d;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   initial begin : watchdog
      do @(posedge clock);
      while (stall_cycles < STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : run_end
      do @(posedge clock);
      while (reset || next_item < stim_q.size() || world_box_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
sv/taabb_pkg.sv
sv/taabb_lane.sv
sv/taabb_merge.sv
sv/transformed_aabb_accumulator.sv
test/tb_transformed_aabb_accumulator.sv
